/* rtl/core/json_request_line_framer_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the JSON request line framer
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef JSON_REQUEST_LINE_FRAMER_TOP_DEFINES_SVH
`define JSON_REQUEST_LINE_FRAMER_TOP_DEFINES_SVH

// same-cycle implication
`define JRLF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JRLF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/jrlf_pkg.sv */
// ----------------------------------------------------------------------------
// jrlf_pkg
// Types, character codes and sizes shared by the request line framer.
// ----------------------------------------------------------------------------
package jrlf_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int PTR_W       = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    M_PRIM  = 4'd0,
    M_LIST  = 4'd1,
    M_OBJB  = 4'd2,
    M_OBJN  = 4'd3,
    M_OBJC  = 4'd4,
    M_STR   = 4'd5,
    M_ESC   = 4'd6,
    M_VAL   = 4'd7,
    M_LIT   = 4'd8,
    M_TRAIL = 4'd9
  } mode_t;

  typedef enum logic [2:0] {
    ST_BUSY   = 3'd0,
    ST_BLANK  = 3'd1,
    ST_WORDS  = 3'd2,
    ST_STRUCT = 3'd3,
    ST_ERROR  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_PUSH2,
    S_POP,
    S_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    SCAN_MORE,
    SCAN_DONE,
    SCAN_ERR
  } scan_res_t;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    mode_t             wdata;
    logic [ADDR_W-1:0] raddr;
  } stk_req_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] echo;
    logic       keep;
    status_t    status;
  } res_t;

endpackage

/* rtl/core/jrlf_stack.sv */
// ----------------------------------------------------------------------------
// jrlf_stack
// Mode stack memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module jrlf_stack
  import jrlf_pkg::*;
(
  input  logic     clk,
  input  stk_req_t req,
  output mode_t    rd_data
);

  mode_t mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

/* rtl/core/jrlf_scan.sv */
// ----------------------------------------------------------------------------
// jrlf_scan
// Mode sequencer: one dispatch, push or pop step per cycle for each word.
// ----------------------------------------------------------------------------
module jrlf_scan
  import jrlf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output res_t       res,
  input  logic       out_ready,
  output stk_req_t   stk,
  input  mode_t      stk_rd
);

  seq_state_t       state, state_next;
  mode_t            cur_mode, cur_mode_next;
  logic [PTR_W-1:0] ptr, ptr_next;
  logic             plain_line, plain_line_next;
  logic             saw_word, saw_word_next;
  logic             draining, draining_next;
  logic [7:0]       byte_q, byte_q_next;
  logic             keep_q, keep_q_next;
  status_t          status_q, status_q_next;
  mode_t            push2_val, push2_val_next;
  logic             pop_cont, pop_cont_next;

  logic             full, empty, sp, open_br, delim;
  logic [PTR_W-1:0] ptr_inc, ptr_dec;
  logic             fin, do_push, need2, push_cont, do_pop, pop_cont_v;
  scan_res_t        fin_res;
  mode_t            push_val, after_mode, second_val;

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF;
  endfunction

  assign ptr_inc = ptr + PTR_W'(1);
  assign ptr_dec = ptr - PTR_W'(1);
  assign full    = (ptr == PTR_W'(STACK_DEPTH));
  assign empty   = (ptr == '0);
  assign sp      = (byte_q == CH_SPACE) || (byte_q == CH_TAB);
  assign open_br = (byte_q == CH_LBRACK) || (byte_q == CH_LBRACE);
  assign delim   = sp || byte_q == CH_LF || byte_q == CH_COMMA || byte_q == CH_RBRACK ||
                   byte_q == CH_RBRACE || byte_q == CH_COLON;

  assign in_ready   = (state == S_IDLE);
  assign res.valid  = (state == S_OUT);
  assign res.echo   = byte_q;
  assign res.keep   = keep_q;
  assign res.status = status_q;

  always_comb begin
    state_next      = state;
    cur_mode_next   = cur_mode;
    ptr_next        = ptr;
    plain_line_next = plain_line;
    saw_word_next   = saw_word;
    draining_next   = draining;
    byte_q_next     = byte_q;
    keep_q_next     = keep_q;
    status_q_next   = status_q;
    push2_val_next  = push2_val;
    pop_cont_next   = pop_cont;

    fin        = 1'b0;
    fin_res    = SCAN_MORE;
    do_push    = 1'b0;
    need2      = 1'b0;
    push_cont  = 1'b0;
    do_pop     = 1'b0;
    pop_cont_v = 1'b0;
    push_val   = M_PRIM;
    after_mode = cur_mode;
    second_val = M_PRIM;

    stk.we    = 1'b0;
    stk.waddr = ptr[ADDR_W-1:0];
    stk.wdata = M_PRIM;
    stk.raddr = ptr_dec[ADDR_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          byte_q_next   = in_byte;
          status_q_next = ST_BUSY;
          if (in_byte == CH_CR) begin
            keep_q_next = 1'b0;
            state_next  = S_OUT;
          end else if (draining) begin
            keep_q_next = 1'b0;
            if (in_byte == CH_LF) begin
              draining_next   = 1'b0;
              status_q_next   = ST_ERROR;
              cur_mode_next   = M_PRIM;
              ptr_next        = '0;
              plain_line_next = 1'b1;
              saw_word_next   = 1'b0;
            end
            state_next = S_OUT;
          end else begin
            keep_q_next = 1'b1;
            if (!is_blank(in_byte)) begin
              saw_word_next = 1'b1;
            end
            state_next = S_DISP;
          end
        end
      end

      S_DISP: begin
        if (sp && (cur_mode == M_PRIM || cur_mode == M_LIST || cur_mode == M_OBJB ||
                   cur_mode == M_VAL || cur_mode == M_TRAIL)) begin
          fin = 1'b1;
        end else if (byte_q == CH_LF &&
                     (cur_mode == M_LIST || cur_mode == M_OBJB || cur_mode == M_VAL)) begin
          fin = 1'b1;
        end else begin
          unique case (cur_mode)
            M_PRIM: begin
              if (byte_q == CH_LF) begin
                fin     = 1'b1;
                fin_res = SCAN_DONE;
              end else if (open_br) begin
                do_push    = 1'b1;
                push_val   = M_TRAIL;
                need2      = 1'b1;
                second_val = (byte_q == CH_LBRACK) ? M_LIST : M_OBJB;
                after_mode = M_VAL;
              end else if (byte_q == CH_QUOTE) begin
                do_push    = 1'b1;
                push_val   = M_TRAIL;
                after_mode = M_STR;
              end else begin
                fin = 1'b1;
              end
            end
            M_LIST: begin
              if (byte_q == CH_COMMA) begin
                do_push    = 1'b1;
                push_val   = M_LIST;
                after_mode = M_VAL;
              end else if (byte_q == CH_RBRACK) begin
                do_pop = 1'b1;
              end else begin
                fin     = 1'b1;
                fin_res = SCAN_ERR;
              end
            end
            M_OBJB: begin
              if (byte_q == CH_RBRACE) begin
                do_pop = 1'b1;
              end else begin
                do_push    = 1'b1;
                push_val   = M_OBJC;
                after_mode = M_VAL;
                push_cont  = 1'b1;
              end
            end
            M_OBJN: begin
              if (byte_q == CH_RBRACE) begin
                do_pop = 1'b1;
              end else if (byte_q == CH_COMMA) begin
                do_push    = 1'b1;
                push_val   = M_OBJC;
                after_mode = M_VAL;
              end else begin
                fin = 1'b1;
              end
            end
            M_OBJC: begin
              if (byte_q == CH_COLON) begin
                do_push    = 1'b1;
                push_val   = M_OBJN;
                after_mode = M_VAL;
              end else begin
                fin     = 1'b1;
                fin_res = SCAN_ERR;
              end
            end
            M_STR: begin
              if (byte_q == CH_BSLASH) begin
                cur_mode_next = M_ESC;
                fin           = 1'b1;
              end else if (byte_q == CH_QUOTE) begin
                do_pop = 1'b1;
              end else begin
                fin = 1'b1;
              end
            end
            M_ESC: begin
              cur_mode_next = M_STR;
              fin           = 1'b1;
            end
            M_VAL: begin
              if (open_br) begin
                do_push    = 1'b1;
                push_val   = M_VAL;
                need2      = 1'b1;
                second_val = (byte_q == CH_LBRACK) ? M_LIST : M_OBJB;
              end else if (byte_q == CH_QUOTE) begin
                do_push    = 1'b1;
                push_val   = M_VAL;
                after_mode = M_STR;
              end else begin
                cur_mode_next = M_LIT;
              end
            end
            M_LIT: begin
              if (delim) begin
                do_pop     = 1'b1;
                pop_cont_v = 1'b1;
              end else begin
                fin = 1'b1;
              end
            end
            M_TRAIL: begin
              fin     = 1'b1;
              fin_res = (byte_q == CH_LF) ? SCAN_DONE : SCAN_ERR;
            end
            default: begin
              cur_mode_next = M_PRIM;
              fin           = 1'b1;
            end
          endcase
        end

        if (do_push) begin
          if (full) begin
            fin     = 1'b1;
            fin_res = SCAN_ERR;
          end else begin
            stk.we        = 1'b1;
            stk.wdata     = push_val;
            ptr_next      = ptr_inc;
            cur_mode_next = after_mode;
            if (need2) begin
              push2_val_next = second_val;
              state_next     = S_PUSH2;
            end else if (!push_cont) begin
              fin = 1'b1;
            end
          end
        end

        if (do_pop) begin
          if (empty) begin
            fin     = 1'b1;
            fin_res = SCAN_ERR;
          end else begin
            ptr_next      = ptr_dec;
            pop_cont_next = pop_cont_v;
            state_next    = S_POP;
          end
        end
      end

      S_PUSH2: begin
        fin = 1'b1;
        if (full) begin
          fin_res = SCAN_ERR;
        end else begin
          stk.we          = 1'b1;
          stk.wdata       = push2_val;
          ptr_next        = ptr_inc;
          plain_line_next = 1'b0;
        end
      end

      S_POP: begin
        cur_mode_next = stk_rd;
        if (pop_cont) begin
          state_next = S_DISP;
        end else begin
          fin = 1'b1;
        end
      end

      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fin) begin
      state_next = S_OUT;
      case (fin_res)
        SCAN_DONE: begin
          status_q_next   = plain_line ? (saw_word ? ST_WORDS : ST_BLANK) : ST_STRUCT;
          cur_mode_next   = M_PRIM;
          ptr_next        = '0;
          plain_line_next = 1'b1;
          saw_word_next   = 1'b0;
        end
        SCAN_ERR: begin
          draining_next = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur_mode   <= M_PRIM;
      ptr        <= '0;
      plain_line <= 1'b1;
      saw_word   <= 1'b0;
      draining   <= 1'b0;
      pop_cont   <= 1'b0;
    end else begin
      state      <= state_next;
      cur_mode   <= cur_mode_next;
      ptr        <= ptr_next;
      plain_line <= plain_line_next;
      saw_word   <= saw_word_next;
      draining   <= draining_next;
      pop_cont   <= pop_cont_next;
    end
  end

  always_ff @(posedge clk) begin
    byte_q    <= byte_q_next;
    keep_q    <= keep_q_next;
    status_q  <= status_q_next;
    push2_val <= push2_val_next;
  end

endmodule

/* rtl/core/json_request_line_framer_top.sv */
// ----------------------------------------------------------------------------
// json_request_line_framer_top
// Frames newline-terminated text requests and classifies each one.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one text byte per word. m_* channel returns one word
//   per input byte: the byte echoed on m_tdata, a keep flag and a line status
//   on m_tuser (0 in progress, 1 blank, 2 plain words, 3 structured JSON,
//   4 error). Each byte runs through a mode sequencer that does one dispatch,
//   push or pop a cycle against a mode stack with registered read.
//   A dropped or discarded byte goes straight to the output stage; any other
//   byte is dispatched and may then need a second push, a pop or a
//   re-dispatch. s_tready is high only while the sequencer idles, so a new
//   byte is taken only after the last result went to the output register.
//   Results sit in an output register; a stall on m_tready holds the word
//   and the sequencer waits with its finished result until the register
//   frees up. Reset clears the mode, stack pointer and flags; stack contents
//   need no clearing.
// ----------------------------------------------------------------------------
module json_request_line_framer_top
  import jrlf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] echo_byte
  output logic [3:0] m_tuser    // [0] keep, [3:1] status
);

  stk_req_t   stk;
  mode_t      stk_rd;
  res_t       res;
  logic       out_ready;
  logic [7:0] echo_q;
  logic       keep_q;
  status_t    status_q;

  assign out_ready = !m_tvalid || m_tready;

  jrlf_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .res       (res),
    .out_ready (out_ready),
    .stk       (stk),
    .stk_rd    (stk_rd)
  );

  jrlf_stack u_stack (
    .clk     (clk),
    .req     (stk),
    .rd_data (stk_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid && out_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && out_ready) begin
      echo_q   <= res.echo;
      keep_q   <= res.keep;
      status_q <= res.status;
    end
  end

  assign m_tdata = echo_q;
  assign m_tuser = {status_q, keep_q};

endmodule

/* rtl/core/jrlf_checker.sv */
// ----------------------------------------------------------------------------
// jrlf_checker
// Port-level checks on the result stream of the request line framer.
// ----------------------------------------------------------------------------
`include "json_request_line_framer_top_defines.svh"

module jrlf_checker
  import jrlf_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [3:0] m_tuser
);

  logic        line_end;
  logic        in_seen;
  logic        err_out, end_out, cr_out, stall;
  logic        lf_kept, lf_dropped, cr_clean;
  logic [2:0]  status;
  logic [11:0] m_word;

  assign status     = m_tuser[3:1];
  assign m_word     = {m_tuser, m_tdata};
  assign line_end   = (status == ST_BLANK) || (status == ST_WORDS) || (status == ST_STRUCT);
  assign in_seen    = s_tvalid && s_tready;
  assign err_out    = m_tvalid && (status == ST_ERROR);
  assign end_out    = m_tvalid && line_end;
  assign cr_out     = m_tvalid && (m_tdata == CH_CR);
  assign stall      = m_tvalid && !m_tready;
  assign lf_kept    = (m_tdata == CH_LF) && m_tuser[0];
  assign lf_dropped = (m_tdata == CH_LF) && !m_tuser[0];
  assign cr_clean   = !m_tuser[0] && (status == ST_BUSY);

  `JRLF_ASSERT_IMPL(a_err_on_dropped_lf, err_out, lf_dropped, "error not on a dropped newline")
  `JRLF_ASSERT_IMPL(a_end_on_kept_lf, end_out, lf_kept, "line outcome not on a kept newline")
  `JRLF_ASSERT_IMPL(a_cr_dropped, cr_out, cr_clean, "carriage return not dropped cleanly")
  `JRLF_ASSERT_NEXT(a_no_accept_twice, in_seen, !s_tready, "sequencer ready after a word")
  `JRLF_ASSERT_NEXT(a_stall_hold, stall, m_tvalid && $stable(m_word), "stalled word changed")

endmodule

bind json_request_line_framer_top jrlf_checker u_jrlf_checker (.*);

/* dv/json_request_line_framer_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_request_line_framer_top_test
// Streams text bytes into the framer and checks every returned word (echo,
// keep flag, line status) against a line scanner kept in the bench. Short
// directed lines come first. Random well-formed JSON, broken JSON, deep
// nesting, plain words, blank lines and raw noise follow, under three
// idling patterns.
// ----------------------------------------------------------------------------
module json_request_line_framer_top_test;
  import jrlf_pkg::*;

  localparam int RAND_ITEMS  = 1350;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic [7:0] echo;
    logic       keep;
    status_t    status;
  } framed_t;

  class line_framer_board;
    framed_t framed_q[$];
    mode_t   mode;
    mode_t   mode_stk[STACK_DEPTH];
    int      depth;
    bit      plain;
    bit      worded;
    bit      discarding;
    int      errors;

    function new();
      restart();
      discarding = 1'b0;
      errors     = 0;
    endfunction

    function void restart();
      mode   = M_PRIM;
      depth  = 0;
      plain  = 1'b1;
      worded = 1'b0;
    endfunction

    function bit push(mode_t m);
      if (depth >= STACK_DEPTH) return 1'b0;
      mode_stk[depth] = m;
      depth++;
      return 1'b1;
    endfunction

    function bit pop();
      if (depth == 0) return 1'b0;
      depth--;
      mode = mode_stk[depth];
      return 1'b1;
    endfunction

    function int pending();
      return framed_q.size();
    endfunction

    function void take_byte(logic [7:0] c);
      framed_t   f;
      scan_res_t r;
      bit        sp;
      bit        again;
      f.echo   = c;
      f.keep   = 1'b0;
      f.status = ST_BUSY;
      sp       = (c == CH_SPACE) || (c == CH_TAB);
      if (c == CH_CR) begin
        // dropped everywhere
      end else if (discarding) begin
        if (c == CH_LF) begin
          discarding = 1'b0;
          restart();
          f.status = ST_ERROR;
        end
      end else begin
        f.keep = 1'b1;
        if (!(c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF})) worded = 1'b1;
        r     = SCAN_MORE;
        again = 1'b1;
        while (again) begin
          again = 1'b0;
          if (sp && (mode inside {M_PRIM, M_LIST, M_OBJB, M_VAL, M_TRAIL})) begin
          end else if (c == CH_LF && (mode inside {M_LIST, M_OBJB, M_VAL})) begin
          end else begin
            case (mode)
              M_PRIM: begin
                if (c == CH_LF) begin
                  r = SCAN_DONE;
                end else if (c == CH_LBRACK || c == CH_LBRACE) begin
                  if (!push(M_TRAIL) || !push(c == CH_LBRACK ? M_LIST : M_OBJB)) begin
                    r = SCAN_ERR;
                  end else begin
                    plain = 1'b0;
                    mode  = M_VAL;
                  end
                end else if (c == CH_QUOTE) begin
                  if (!push(M_TRAIL)) r = SCAN_ERR;
                  else mode = M_STR;
                end
              end
              M_LIST: begin
                if (c == CH_COMMA) begin
                  if (!push(M_LIST)) r = SCAN_ERR;
                  else mode = M_VAL;
                end else if (c == CH_RBRACK) begin
                  if (!pop()) r = SCAN_ERR;
                end else begin
                  r = SCAN_ERR;
                end
              end
              M_OBJB: begin
                if (c == CH_RBRACE) begin
                  if (!pop()) r = SCAN_ERR;
                end else if (!push(M_OBJC)) begin
                  r = SCAN_ERR;
                end else begin
                  mode  = M_VAL;
                  again = 1'b1;
                end
              end
              M_OBJN: begin
                if (c == CH_RBRACE) begin
                  if (!pop()) r = SCAN_ERR;
                end else if (c == CH_COMMA) begin
                  if (!push(M_OBJC)) r = SCAN_ERR;
                  else mode = M_VAL;
                end
              end
              M_OBJC: begin
                if (c == CH_COLON) begin
                  if (!push(M_OBJN)) r = SCAN_ERR;
                  else mode = M_VAL;
                end else begin
                  r = SCAN_ERR;
                end
              end
              M_STR: begin
                if (c == CH_BSLASH) begin
                  mode = M_ESC;
                end else if (c == CH_QUOTE) begin
                  if (!pop()) r = SCAN_ERR;
                end
              end
              M_ESC: mode = M_STR;
              M_VAL: begin
                if (c == CH_LBRACK || c == CH_LBRACE) begin
                  if (!push(M_VAL) || !push(c == CH_LBRACK ? M_LIST : M_OBJB)) r = SCAN_ERR;
                  else plain = 1'b0;
                end else if (c == CH_QUOTE) begin
                  if (!push(M_VAL)) r = SCAN_ERR;
                  else mode = M_STR;
                end else begin
                  mode  = M_LIT;
                  again = 1'b1;
                end
              end
              M_LIT: begin
                if (sp || c inside {CH_LF, CH_COMMA, CH_RBRACK, CH_RBRACE, CH_COLON}) begin
                  if (!pop()) r = SCAN_ERR;
                  else again = 1'b1;
                end
              end
              M_TRAIL: r = (c == CH_LF) ? SCAN_DONE : SCAN_ERR;
              default: mode = M_PRIM;
            endcase
          end
        end
        if (r == SCAN_DONE) begin
          f.status = plain ? (worded ? ST_WORDS : ST_BLANK) : ST_STRUCT;
          restart();
        end else if (r == SCAN_ERR) begin
          discarding = 1'b1;
        end
      end
      framed_q.insert(framed_q.size(), f);
    endfunction

    task report(string what);
      if (errors < 40) $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
    endtask

    task match_word(logic [7:0] d, logic [3:0] u);
      framed_t f;
      if (framed_q.size() == 0) begin
        report($sformatf("word %h/%h with nothing pending", d, u));
        return;
      end
      f = framed_q.pop_front();
      if ({u, d} !== {f.status, f.keep, f.echo})
        report($sformatf("echo %h/%h keep %b/%b status %0d/%0d (got/exp)",
                         d, f.echo, u[0], f.keep, u[3:1], f.status));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [3:0] m_tuser;

  line_framer_board frame_chk;
  logic [7:0]       stim_q[$];
  int               tx_idle_pct = 13;
  int               rx_idle_pct = 48;

  json_request_line_framer_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) frame_chk.take_byte(s_tdata);
    if (!rst && m_tvalid && m_tready) frame_chk.match_word(m_tdata, m_tuser);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic void put(logic [7:0] b);
    stim_q.insert(stim_q.size(), b);
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void put_ws();
    case ($urandom_range(0, 11))
      0: put(CH_SPACE);
      1: put(CH_TAB);
      2: put(CH_CR);
      3: begin
        put(CH_SPACE);
        put(CH_SPACE);
      end
      4: put(CH_LF);
      default: ;
    endcase
  endfunction

  function automatic void gen_string();
    logic [7:0] b;
    put(CH_QUOTE);
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 7))
        0: begin
          put(CH_BSLASH);
          put(8'($urandom_range(0, 255)));
        end
        1: put(8'($urandom_range(8'h80, 8'hff)));
        default: begin
          b = 8'($urandom_range(8'h20, 8'h7e));
          put((b == CH_QUOTE || b == CH_BSLASH) ? 8'h61 : b);
        end
      endcase
    end
    put(CH_QUOTE);
  endfunction

  function automatic void gen_value(int lvl);
    int n;
    case ((lvl >= 5) ? $urandom_range(0, 1) : $urandom_range(0, 3))
      0: begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 2) == 0) put(8'($urandom_range(8'h30, 8'h39)));
          else put(8'($urandom_range(8'h61, 8'h7a)));
        end
      end
      1: gen_string();
      2: begin
        put(CH_LBRACK);
        put_ws();
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) begin
            put(CH_COMMA);
            put_ws();
          end
          gen_value(lvl + 1);
          put_ws();
        end
        put(CH_RBRACK);
      end
      default: begin
        put(CH_LBRACE);
        put_ws();
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) begin
            put(CH_COMMA);
            put_ws();
          end
          gen_string();
          put_ws();
          put(CH_COLON);
          put_ws();
          gen_value(lvl + 1);
          put_ws();
        end
        put(CH_RBRACE);
      end
    endcase
  endfunction

  function automatic void gen_line();
    int         kind;
    int         start;
    int         n;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      put_ws();
      gen_value(0);
      put_ws();
    end else if (kind < 60) begin
      // broken JSON: one byte corrupted or junk appended
      start = stim_q.size();
      gen_value(0);
      if ($urandom_range(0, 1))
        stim_q[$urandom_range(start, stim_q.size() - 1)] = 8'($urandom_range(0, 255));
      else put(8'($urandom_range(0, 255)));
    end else if (kind < 70) begin
      repeat ($urandom_range(1, 12)) begin
        b = 8'($urandom_range(8'h21, 8'h7e));
        if ($urandom_range(0, 3) == 0) put(CH_SPACE);
        else put((b == CH_LBRACK || b == CH_LBRACE || b == CH_QUOTE) ? 8'h77 : b);
      end
    end else if (kind < 78) begin
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(0, 3))
          0: put(CH_SPACE);
          1: put(CH_TAB);
          2: put(CH_VT);
          default: put(CH_FF);
        endcase
      end
    end else if (kind < 86) begin
      // nesting around the stack limit
      n = $urandom_range(13, 18);
      repeat (n) put(CH_LBRACK);
      put(8'($urandom_range(8'h30, 8'h39)));
      repeat (n) put(CH_RBRACK);
      if ($urandom_range(0, 3) == 0) put(CH_RBRACK);
    end else begin
      repeat ($urandom_range(1, 10)) put(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 3) == 0) put(CH_CR);
    put(CH_LF);
  endfunction

  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (frame_chk.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int n_dir;
    frame_chk = new();

    put(CH_LF);
    put(8'h00);
    put(8'hff);
    put(CH_CR);
    put(CH_LF);
    put_str("[\"\\x\"]\n");
    // newline as the failing byte, then a drained byte
    put_str("{x y\nq\n");
    put_str("{}\n");
    put(CH_SPACE);
    put(CH_TAB);
    put(CH_VT);
    put(CH_FF);
    put(CH_LF);
    n_dir = stim_q.size();
    while (stim_q.size() < n_dir + RAND_ITEMS) gen_line();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < stim_q.size(); i++) begin
      if (i == n_dir + RAND_ITEMS / 3) begin
        drain_results();
        tx_idle_pct = 48;
        rx_idle_pct = 13;
      end else if (i == n_dir + 2 * RAND_ITEMS / 3) begin
        drain_results();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_byte(stim_q[i]);
    end
    s_tvalid <= 1'b0;

    while (frame_chk.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (frame_chk.errors == 0 && frame_chk.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
